[src/prd_pkg.sv]
// Shared types and a helper function for the point-to-ray distance pipeline.
// No dependencies; every other file but prd_chk refers to this package by scoped names.
package prd_pkg;

  localparam int COORD_W        = 32;
  localparam int T_W            = 31;
  localparam int DIST_W         = 32;
  localparam int RAD_W          = 64;
  localparam int REM_W          = 35;
  localparam int ROOT_PER_STAGE = 2;
  localparam int ROOT_STAGES    = DIST_W / ROOT_PER_STAGE;

  // Side information that rides along with the radicand through the root stages.
  typedef struct packed {
    logic           sat;
    logic           behind;
    logic [T_W-1:0] ray_param;
  } side_t;

  typedef struct packed {
    logic              behind_origin;
    logic [T_W-1:0]    ray_param;
    logic [DIST_W-1:0] distance;
  } res_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIST_W-1:0] root;
  } sq_st_t;

  // One digit of the restoring square root: bring down two radicand bits,
  // try to subtract 4*root+1 and shift the new root bit in.
  function automatic sq_st_t sqrt_step(sq_st_t a, logic [1:0] pair);
    logic [REM_W-1:0] r;
    logic [REM_W-1:0] trial;
    sq_st_t           o;
    r     = {a.rem[REM_W-3:0], pair};
    trial = {1'b0, a.root, 2'b01};
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {a.root[DIST_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {a.root[DIST_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[src/point_to_ray_distance_unit.sv]
// Point-to-ray distance unit: top level tying the pipeline parts together.
// Depends on prd_pkg, prd_proj, prd_len, prd_sqrt and prd_skid.
//
// Usage: each item on the in_ channel carries a ray origin, a unit ray
// direction and a query point, all signed fixed point with FRAC_BITS
// fraction bits. For each item the out_ channel returns one item with the
// distance from the point to the nearest ray point, the ray parameter t of
// that point (clamped at zero, saturated) and a flag that is set when the
// point lies behind the origin. Distances beyond the 32-bit range saturate.
// From acceptance to out_tvalid an item passes six projection stages,
// three squared-length stages, sixteen square-root stages (two root bits
// each) and the output register. One item is accepted every cycle while
// in_tready is high. When the receiver stalls, the output register holds
// its item and one more item lands in a skid entry; only then does
// in_tready drop and the whole pipeline freeze, so nothing is lost or
// repeated. Reset clears all valid bits; no item is in flight afterwards.
module point_to_ray_distance_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, point_x, point_y,
  // point_z, 32 bits each, lowest first
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance [31:0], ray_param [62:32], behind_origin [63]
  output logic [63:0]  out_tdata
);

  localparam int DW = 65 - FRAC_BITS;

  logic                           ce;
  logic [2:0][31:0]               org, dir, pt;
  logic                           proj_v, len_v, sqrt_v;
  logic [2:0][DW-1:0]             delta;
  logic [prd_pkg::T_W-1:0]        proj_t;
  logic                           proj_behind;
  logic [prd_pkg::RAD_W-1:0]      radicand;
  prd_pkg::side_t                 len_side, sqrt_side;
  logic [prd_pkg::DIST_W-1:0]     root;
  prd_pkg::res_t                  res, out_res;

  assign in_tready = ce;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign org[i] = in_tdata[32*i      +: 32];
    assign dir[i] = in_tdata[32*(i+3)  +: 32];
    assign pt[i]  = in_tdata[32*(i+6)  +: 32];
  end

  prd_proj #(
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_tvalid),
    .org       (org),
    .dir       (dir),
    .pt        (pt),
    .out_valid (proj_v),
    .delta     (delta),
    .ray_param (proj_t),
    .behind    (proj_behind)
  );

  prd_len #(
    .DW (DW)
  ) u_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (proj_v),
    .delta     (delta),
    .ray_param (proj_t),
    .behind    (proj_behind),
    .out_valid (len_v),
    .radicand  (radicand),
    .side      (len_side)
  );

  prd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (len_v),
    .radicand  (radicand),
    .in_side   (len_side),
    .out_valid (sqrt_v),
    .root      (root),
    .out_side  (sqrt_side)
  );

  always_comb begin
    res.distance      = sqrt_side.sat ? '1 : root;
    res.ray_param     = sqrt_side.ray_param;
    res.behind_origin = sqrt_side.behind;
  end

  prd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sqrt_v),
    .in_res    (res),
    .ce        (ce),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res;

endmodule

[src/prd_proj.sv]
// Projection stages: difference, dot product, clamped ray parameter and the
// offset from the nearest ray point. Six register stages. Uses prd_pkg.
module prd_proj #(
  parameter int FRAC_BITS = 16,
  parameter int DW        = 49
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [2:0][31:0]             org,
  input  logic [2:0][31:0]             dir,
  input  logic [2:0][31:0]             pt,
  output logic                         out_valid,
  output logic [2:0][DW-1:0]           delta,
  output logic [prd_pkg::T_W-1:0]      ray_param,
  output logic                         behind
);

  logic [5:0] vld_r;

  logic signed [32:0] diff1_r [3];
  logic signed [31:0] dir1_r  [3];
  logic signed [64:0] prod2_r [3];
  logic signed [32:0] diff2_r [3];
  logic signed [31:0] dir2_r  [3];
  logic signed [66:0] dot3_r;
  logic signed [32:0] diff3_r [3];
  logic signed [31:0] dir3_r  [3];
  logic signed [32:0] diff4_r [3];
  logic signed [31:0] dir4_r  [3];
  logic [prd_pkg::T_W-1:0] t4_r, t5_r, t6_r;
  logic                    behind4_r, behind5_r, behind6_r;
  logic signed [63:0] pm5_r   [3];
  logic signed [32:0] diff5_r [3];
  logic [DW-1:0]      d6_r    [3];

  logic [prd_pkg::T_W-1:0] t4_nxt;
  logic                    behind4_nxt;
  logic signed [63:0]      pm_sh [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  // The dot product is exact; a negative sign clamps t to zero, and a zero t
  // makes the nearest-point offset vanish so the origin distance falls out.
  always_comb begin
    behind4_nxt = dot3_r[66];
    if (behind4_nxt) begin
      t4_nxt = '0;
    end else if (|dot3_r[65:FRAC_BITS+31]) begin
      t4_nxt = '1;
    end else begin
      t4_nxt = dot3_r[FRAC_BITS+30 -: 31];
    end
    for (int i = 0; i < 3; i++) begin
      pm_sh[i] = pm5_r[i] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        diff1_r[i] <= $signed({pt[i][31], pt[i]}) - $signed({org[i][31], org[i]});
        dir1_r[i]  <= $signed(dir[i]);
        prod2_r[i] <= diff1_r[i] * dir1_r[i];
        diff2_r[i] <= diff1_r[i];
        dir2_r[i]  <= dir1_r[i];
        diff3_r[i] <= diff2_r[i];
        dir3_r[i]  <= dir2_r[i];
        diff4_r[i] <= diff3_r[i];
        dir4_r[i]  <= dir3_r[i];
        pm5_r[i]   <= dir4_r[i] * $signed({1'b0, t4_r});
        diff5_r[i] <= diff4_r[i];
        d6_r[i]    <= {{(DW-33){diff5_r[i][32]}}, diff5_r[i]} - pm_sh[i][DW-1:0];
      end
      dot3_r    <= {{2{prod2_r[0][64]}}, prod2_r[0]} + {{2{prod2_r[1][64]}}, prod2_r[1]}
                 + {{2{prod2_r[2][64]}}, prod2_r[2]};
      t4_r      <= t4_nxt;
      behind4_r <= behind4_nxt;
      t5_r      <= t4_r;
      behind5_r <= behind4_r;
      t6_r      <= t5_r;
      behind6_r <= behind5_r;
    end
  end

  assign out_valid = vld_r[5];
  assign delta     = {d6_r[2], d6_r[1], d6_r[0]};
  assign ray_param = t6_r;
  assign behind    = behind6_r;

endmodule

[src/prd_len.sv]
// Squared-length stages: magnitudes, squares and their saturating sum.
// Three register stages. Uses prd_pkg.
module prd_len #(
  parameter int DW = 49
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [2:0][DW-1:0]           delta,
  input  logic [prd_pkg::T_W-1:0]      ray_param,
  input  logic                         behind,
  output logic                         out_valid,
  output logic [prd_pkg::RAD_W-1:0]    radicand,
  output prd_pkg::side_t               side
);

  logic [2:0] vld_r;
  logic [31:0] mag7_r [3];
  logic [63:0] sq8_r  [3];
  logic        over7_r, over8_r;
  logic [prd_pkg::T_W-1:0] t7_r, t8_r;
  logic        behind7_r, behind8_r;
  logic [prd_pkg::RAD_W-1:0] sum9_r;
  prd_pkg::side_t            side9_r;

  logic [DW-1:0] mag_nxt [3];
  logic          over_nxt;
  logic [65:0]   sum_nxt;

  always_comb begin
    over_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = delta[i][DW-1] ? (~delta[i] + 1'b1) : delta[i];
      over_nxt   = over_nxt | (|mag_nxt[i][DW-1:32]);
    end
    sum_nxt = {2'b00, sq8_r[0]} + {2'b00, sq8_r[1]} + {2'b00, sq8_r[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mag7_r[i] <= mag_nxt[i][31:0];
        sq8_r[i]  <= mag7_r[i] * mag7_r[i];
      end
      over7_r   <= over_nxt;
      t7_r      <= ray_param;
      behind7_r <= behind;
      over8_r   <= over7_r;
      t8_r      <= t7_r;
      behind8_r <= behind7_r;
      sum9_r            <= sum_nxt[63:0];
      side9_r.sat       <= over8_r | (|sum_nxt[65:64]);
      side9_r.behind    <= behind8_r;
      side9_r.ray_param <= t8_r;
    end
  end

  assign out_valid = vld_r[2];
  assign radicand  = sum9_r;
  assign side      = side9_r;

endmodule

[src/prd_sqrt.sv]
// Pipelined floor square root of a 64-bit radicand, two root bits per stage.
// Side information travels alongside. Uses prd_pkg.
module prd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [prd_pkg::RAD_W-1:0]     radicand,
  input  prd_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [prd_pkg::DIST_W-1:0]    root,
  output prd_pkg::side_t                out_side
);

  localparam int NST = prd_pkg::ROOT_STAGES;
  localparam int PER = prd_pkg::ROOT_PER_STAGE;

  logic                      vld_r  [NST];
  logic [prd_pkg::RAD_W-1:0] rad_r  [NST];
  prd_pkg::sq_st_t           st_r   [NST];
  prd_pkg::side_t            side_r [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic                      vld_in;
    logic [prd_pkg::RAD_W-1:0] rad_in;
    prd_pkg::sq_st_t           st_in;
    prd_pkg::side_t            side_in;
    prd_pkg::sq_st_t           st_nxt;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rad_in  = radicand;
      assign st_in   = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rad_in  = rad_r[s-1];
      assign st_in   = st_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      st_nxt = st_in;
      for (int k = 0; k < PER; k++) begin
        st_nxt = prd_pkg::sqrt_step(st_nxt, rad_in[prd_pkg::RAD_W-1-2*k -: 2]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (ce) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rad_r[s]  <= rad_in << (2 * PER);
        st_r[s]   <= st_nxt;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign root      = st_r[NST-1].root;
  assign out_side  = side_r[NST-1];

endmodule

[src/prd_skid.sv]
// Output register with one skid entry; it frees the pipeline from the
// receiver's ready. Uses prd_pkg for the result type.
module prd_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  prd_pkg::res_t  in_res,
  output logic           ce,
  output logic           out_valid,
  input  logic           out_ready,
  output prd_pkg::res_t  out_res
);

  logic          out_v_r, skid_v_r;
  prd_pkg::res_t out_r, skid_r;
  logic          out_v_nxt, skid_v_nxt;
  prd_pkg::res_t out_nxt, skid_nxt;
  logic          take;

  assign ce = !skid_v_r;

  always_comb begin
    take       = out_ready || !out_v_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (take) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = in_res;
        out_v_nxt = in_valid;
      end
    end else if (in_valid && ce) begin
      // The held result is still waiting, so park the new one beside it.
      skid_nxt   = in_res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

[src/prd_chk.sv]
// Port-level checks for the point-to-ray distance unit, bound to the top level.
// Sees only the top level's ports; no package dependency.
module prd_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata
);

  // A held output item must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // A point behind the origin always reports t as zero.
  a_behind_zero_t: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[63] |-> out_tdata[62:32] == 31'd0)
    else $error("behind_origin set with nonzero ray_param");

  // Input back-pressure only appears when an output item is waiting.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with no output item pending");

  // Reset leaves no item on the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind point_to_ray_distance_unit prd_chk u_prd_chk (.*);
